FILE: rtl/tsat_pkg.sv
// tsat_pkg: types, constants and codes shared by the tickless alarm timer
// no dependencies; imported by every module of the block

package tsat_pkg;

    localparam int CNT_W  = 32;
    localparam int OUT_W  = 32;
    localparam int MIN_W  = 8;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_SET_TIMEOUT = 2'd1,
        OP_SERVICE     = 2'd2,
        OP_UNUSED      = 2'd3
    } op_t;

    // register index, taken from paddr[2]
    localparam logic REG_TICKLESS_EN = 1'b0;
    localparam logic REG_MIN_TIMEOUT = 1'b1;

    localparam logic             TICKLESS_EN_RST = 1'b1;
    localparam logic [MIN_W-1:0] MIN_TIMEOUT_RST = MIN_W'(3);

    typedef struct packed {
        op_t                opcode;
        logic signed [31:0] ticks;
    } item_t;

    typedef struct packed {
        logic             announce;
        logic [OUT_W-1:0] announce_ticks;
        logic [OUT_W-1:0] elapsed_ticks;
        logic [OUT_W-1:0] cycle_count;
        logic             timeout_accepted;
        logic             alarm_pending_out;
    } result_t;

    typedef struct packed {
        logic             tickless_enable;
        logic [MIN_W-1:0] min_timeout;
    } cfg_t;

endpackage

FILE: rtl/tsat_cfg.sv
// tsat_cfg: configuration registers behind the register bus port
// depends on tsat_pkg

module tsat_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsat_pkg::ADDR_W-1:0] paddr,
    input  logic [tsat_pkg::DATA_W-1:0] pwdata,
    output logic [tsat_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output tsat_pkg::cfg_t              cfg
);
    import tsat_pkg::*;

    logic             tickless_en_reg;
    logic [MIN_W-1:0] min_timeout_reg;
    logic             wr_en;
    logic             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tickless_en_reg <= TICKLESS_EN_RST;
            min_timeout_reg <= MIN_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TICKLESS_EN: tickless_en_reg <= pwdata[0];
                REG_MIN_TIMEOUT: min_timeout_reg <= pwdata[MIN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_TICKLESS_EN: prdata = DATA_W'(tickless_en_reg);
            REG_MIN_TIMEOUT: prdata = DATA_W'(min_timeout_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.tickless_enable = tickless_en_reg;
    assign cfg.min_timeout     = min_timeout_reg;

endmodule

FILE: rtl/tsat_core.sv
// tsat_core: counter, announce point and alarm state with the per-beat update logic
// depends on tsat_pkg

module tsat_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  tsat_pkg::item_t   item,
    input  tsat_pkg::cfg_t    cfg,
    output tsat_pkg::result_t result
);
    import tsat_pkg::*;

    logic [CNT_W-1:0] counter_reg, counter_next;
    logic [CNT_W-1:0] ann_point_reg, ann_point_next;
    logic [CNT_W-1:0] compare_reg, compare_next;
    logic             armed_reg, armed_next;
    logic             pending_reg, pending_next;

    logic [CNT_W-1:0] cnt_dec;
    logic [CNT_W-1:0] gap_now;
    logic [CNT_W-1:0] gap_after;
    logic [CNT_W-1:0] min_ext;
    logic [31:0]      min_req;
    logic [31:0]      req;
    logic [31:0]      span;
    logic             refuse;
    logic             announce;
    logic             accepted;

    function automatic logic [CNT_W-1:0] abs_gap(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    always_comb
    begin
        cnt_dec = counter_reg - CNT_W'(1);
        gap_now = abs_gap(ann_point_reg, counter_reg);
        min_ext = CNT_W'(cfg.min_timeout);
        min_req = 32'(cfg.min_timeout);
        req     = unsigned'(item.ticks);
        span    = (req < min_req) ? min_req : req;
        refuse  = pending_reg && (gap_now < min_ext);

        counter_next   = counter_reg;
        ann_point_next = ann_point_reg;
        compare_next   = compare_reg;
        armed_next     = armed_reg;
        pending_next   = pending_reg;
        announce       = 1'b0;
        accepted       = 1'b0;

        unique case (item.opcode)
            OP_TICK:
            begin
                counter_next = cnt_dec;
                if (armed_reg && (cnt_dec == compare_reg))
                begin
                    pending_next = 1'b1;
                end
            end
            OP_SET_TIMEOUT:
            begin
                if (cfg.tickless_enable && !refuse)
                begin
                    compare_next = counter_reg - CNT_W'(span);
                    armed_next   = 1'b1;
                    pending_next = 1'b0;
                    accepted     = 1'b1;
                end
            end
            OP_SERVICE:
            begin
                if (pending_reg)
                begin
                    pending_next   = 1'b0;
                    ann_point_next = counter_reg;
                    announce       = 1'b1;
                end
            end
            OP_UNUSED: ;
            default:   ;
        endcase

        gap_after = abs_gap(ann_point_next, counter_next);

        result.announce          = announce;
        result.announce_ticks    = announce ? OUT_W'(gap_now) : '0;
        result.elapsed_ticks     = cfg.tickless_enable ? OUT_W'(gap_after) : '0;
        result.cycle_count       = OUT_W'(~counter_next);
        result.timeout_accepted  = accepted;
        result.alarm_pending_out = pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '1;
            ann_point_reg <= '1;
            compare_reg   <= '0;
            armed_reg     <= 1'b0;
            pending_reg   <= 1'b0;
        end
        else if (fire)
        begin
            counter_reg   <= counter_next;
            ann_point_reg <= ann_point_next;
            compare_reg   <= compare_next;
            armed_reg     <= armed_next;
            pending_reg   <= pending_next;
        end
    end

endmodule

FILE: rtl/tickless_subsecond_alarm_timer.sv
// tickless_subsecond_alarm_timer: top level, input and result registers around the core
// depends on tsat_pkg, tsat_cfg, tsat_core
//
//   channel   direction  handshake                  payload
//   item      in         item_valid / item_stall    item (item_t)
//   result    out        result_valid / result_stall result (result_t)
//   config    in         psel penable pwrite pready paddr pwdata prdata
//
// one beat per cycle when nothing stalls; a taken item beat goes through the input register, then the result register
// the core state updates as a beat leaves the input register into the result register
// a result waiting under stall holds one more beat in the input register, then item_stall rises
// reset clears the state at once, no clearing pass

module tickless_subsecond_alarm_timer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  tsat_pkg::item_t             item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output tsat_pkg::result_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsat_pkg::ADDR_W-1:0] paddr,
    input  logic [tsat_pkg::DATA_W-1:0] pwdata,
    output logic [tsat_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import tsat_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    result_t core_result;
    logic    result_valid_reg;
    logic    advance;
    logic    fire;

    assign advance    = !result_valid_reg || !result_stall;
    assign fire       = item_valid_reg && advance;
    assign item_stall = item_valid_reg && !advance;

    tsat_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tsat_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            item_reg <= item;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
